>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL, included by mac_identity_hash_derivation.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mihd_pkg.sv
// Constants and hash functions for the MAC identity hash derivation block.
package mihd_pkg;

    localparam int MAC_W       = 48;
    localparam int MAC_BYTES   = 6;
    localparam int HASH_W      = 64;
    localparam int CLIENT_ID_W = 63;
    localparam int STR_MAX     = 24;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

    localparam logic [3:0] UUID_VERSION = 4'h5;
    localparam logic [1:0] UUID_VARIANT = 2'b10;

    // Domain strings as bytes, first byte in the most significant position,
    // each ending in its terminating zero byte.
    localparam int DOM_CID_LEN = 21;
    localparam int DOM_UA_LEN  = 24;
    localparam int DOM_UB_LEN  = 24;
    localparam logic [8*STR_MAX-1:0] DOM_CID =
        192'h4E494E4543524146542D4349442D4D41432D563100;
    localparam logic [8*STR_MAX-1:0] DOM_UA =
        192'h4E494E4543524146542D555549442D4D41432D56312D4100;
    localparam logic [8*STR_MAX-1:0] DOM_UB =
        192'h4E494E4543524146542D555549442D4D41432D56312D4200;

    // One FNV-1a round. The prime is 2^40 + 0x1B3, so the product modulo
    // 2^64 is a sum of shifted copies.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // Folds the first n bytes of s into h; used only to build the seeds.
    function automatic logic [HASH_W-1:0] fnv_fold_str(input logic [HASH_W-1:0] h,
                                                       input logic [8*STR_MAX-1:0] s,
                                                       input int n);
        logic [HASH_W-1:0] acc;
        acc = h;
        for (int i = 0; i < n; i++)
        begin
            acc = fnv_step(acc, s[8*(n-1-i) +: 8]);
        end
        return acc;
    endfunction

    // Byte reversal: byte 0 of v lands in the top byte.
    function automatic logic [HASH_W-1:0] text_order(input logic [HASH_W-1:0] v);
        logic [HASH_W-1:0] r;
        for (int i = 0; i < HASH_W/8; i++)
        begin
            r[HASH_W-1-8*i -: 8] = v[8*i +: 8];
        end
        return r;
    endfunction

    localparam logic [HASH_W-1:0] SEED_CID = fnv_fold_str(FNV_BASIS, DOM_CID, DOM_CID_LEN);
    localparam logic [HASH_W-1:0] SEED_UA  = fnv_fold_str(FNV_BASIS, DOM_UA, DOM_UA_LEN);
    localparam logic [HASH_W-1:0] SEED_UB  = fnv_fold_str(FNV_BASIS, DOM_UB, DOM_UB_LEN);

endpackage

>>> hw/rtl/mac_identity_hash_derivation.sv
// MAC identity hash derivation: checks a 48-bit MAC address and derives a 63-bit
// client id and a version-5 UUID from three seeded FNV-1a 64 hashes of its bytes.
// One address is accepted per cycle unless out_ready low stalls the pipeline. The
// accepting edge loads the first of six hash stages, each folding one MAC byte into
// all three hashes with a constant multiply, and the last hash stage feeds the
// output register. Multicast, all-zero and all-ones addresses come out with
// address_ok low and all other fields zero.
`include "assert_macros.svh"

module mac_identity_hash_derivation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mihd_pkg::MAC_W-1:0]       mac_address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             address_ok,
    output logic [mihd_pkg::CLIENT_ID_W-1:0] client_id,
    output logic [mihd_pkg::HASH_W-1:0]      uuid_upper,
    output logic [mihd_pkg::HASH_W-1:0]      uuid_lower
);
    import mihd_pkg::*;

    localparam int STAGES = MAC_BYTES + 1;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   stage_ready;

    logic [HASH_W-1:0] cid_reg  [MAC_BYTES];
    logic [HASH_W-1:0] cid_next [MAC_BYTES];
    logic [HASH_W-1:0] ua_reg   [MAC_BYTES];
    logic [HASH_W-1:0] ua_next  [MAC_BYTES];
    logic [HASH_W-1:0] ub_reg   [MAC_BYTES];
    logic [HASH_W-1:0] ub_next  [MAC_BYTES];
    logic [MAC_W-1:0]  mac_reg  [MAC_BYTES];
    logic [MAC_W-1:0]  mac_next [MAC_BYTES];
    logic              ok_reg   [MAC_BYTES];
    logic              ok_next  [MAC_BYTES];

    logic                   address_ok_reg, address_ok_next;
    logic [CLIENT_ID_W-1:0] client_id_reg, client_id_next;
    logic [HASH_W-1:0]      uuid_upper_reg, uuid_upper_next;
    logic [HASH_W-1:0]      uuid_lower_reg, uuid_lower_next;

    logic                   in_ok;
    logic [CLIENT_ID_W-1:0] cid_raw;
    logic [HASH_W-1:0]      up_swap;
    logic [HASH_W-1:0]      lo_swap;

    assign in_ok = !mac_address[MAC_W-8] && (mac_address != '0) && (mac_address != '1);

    always_comb
    begin
        stage_ready[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        end
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < STAGES; s++)
        begin
            valid_next[s] = stage_ready[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_comb
    begin
        cid_next = cid_reg;
        ua_next  = ua_reg;
        ub_next  = ub_reg;
        mac_next = mac_reg;
        ok_next  = ok_reg;
        if (stage_ready[0])
        begin
            cid_next[0] = fnv_step(SEED_CID, mac_address[MAC_W-1 -: 8]);
            ua_next[0]  = fnv_step(SEED_UA, mac_address[MAC_W-1 -: 8]);
            ub_next[0]  = fnv_step(SEED_UB, mac_address[MAC_W-1 -: 8]);
            mac_next[0] = mac_address;
            ok_next[0]  = in_ok;
        end
        for (int j = 1; j < MAC_BYTES; j++)
        begin
            if (stage_ready[j])
            begin
                cid_next[j] = fnv_step(cid_reg[j-1], mac_reg[j-1][MAC_W-1-8*j -: 8]);
                ua_next[j]  = fnv_step(ua_reg[j-1], mac_reg[j-1][MAC_W-1-8*j -: 8]);
                ub_next[j]  = fnv_step(ub_reg[j-1], mac_reg[j-1][MAC_W-1-8*j -: 8]);
                mac_next[j] = mac_reg[j-1];
                ok_next[j]  = ok_reg[j-1];
            end
        end
    end

    always_comb
    begin
        cid_raw = cid_reg[MAC_BYTES-1][CLIENT_ID_W-1:0];
        up_swap = text_order(ua_reg[MAC_BYTES-1]);
        lo_swap = text_order(ub_reg[MAC_BYTES-1]);
        up_swap[15:12] = UUID_VERSION;
        lo_swap[HASH_W-1 -: 2] = UUID_VARIANT;

        address_ok_next = address_ok_reg;
        client_id_next  = client_id_reg;
        uuid_upper_next = uuid_upper_reg;
        uuid_lower_next = uuid_lower_reg;
        if (stage_ready[STAGES-1])
        begin
            address_ok_next = ok_reg[MAC_BYTES-1];
            if (ok_reg[MAC_BYTES-1])
            begin
                client_id_next  = (cid_raw == '0) ? {{(CLIENT_ID_W-1){1'b0}}, 1'b1} : cid_raw;
                uuid_upper_next = up_swap;
                uuid_lower_next = lo_swap;
            end
            else
            begin
                client_id_next  = '0;
                uuid_upper_next = '0;
                uuid_lower_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cid_reg        <= cid_next;
        ua_reg         <= ua_next;
        ub_reg         <= ub_next;
        mac_reg        <= mac_next;
        ok_reg         <= ok_next;
        address_ok_reg <= address_ok_next;
        client_id_reg  <= client_id_next;
        uuid_upper_reg <= uuid_upper_next;
        uuid_lower_reg <= uuid_lower_next;
    end

    assign in_ready   = stage_ready[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign address_ok = address_ok_reg;
    assign client_id  = client_id_reg;
    assign uuid_upper = uuid_upper_reg;
    assign uuid_lower = uuid_lower_reg;

    `ASSERT_SAME(a_cid_nonzero, out_valid && address_ok, client_id != '0,
                 "valid beat with zero client id")
    `ASSERT_SAME(a_reject_zero, out_valid && !address_ok,
                 (client_id == '0) && (uuid_upper == '0) && (uuid_lower == '0),
                 "rejected beat with nonzero fields")
    `ASSERT_SAME(a_uuid_marks, out_valid && address_ok,
                 (uuid_upper[15:12] == UUID_VERSION) &&
                 (uuid_lower[HASH_W-1 -: 2] == UUID_VARIANT),
                 "uuid version or variant bits wrong")
    `ASSERT_NEXT(a_drain, valid_reg[STAGES-2] && out_ready, out_valid,
                 "last hash stage did not reach the output")

endmodule

>>> sim/tb_top.sv
// Testbench for mac_identity_hash_derivation: directed and random MAC addresses vs a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [63:0] FNV_PRIME_64  = 64'd1099511628211;
    localparam logic [63:0] FNV_OFFSET_64 = 64'hcbf29ce484222325;
    localparam logic [191:0] CLIENT_TAG_STR =
        192'h4E494E4543524146542D4349442D4D41432D563100;
    localparam logic [191:0] UUID_A_DOMAIN =
        192'h4E494E4543524146542D555549442D4D41432D56312D4100;
    localparam logic [191:0] UUID_B_DOMAIN =
        192'h4E494E4543524146542D555549442D4D41432D56312D4200;
    localparam int CLIENT_TAG_LEN  = 21;
    localparam int UUID_DOMAIN_LEN = 24;
    localparam int MAC_LEN         = 6;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int QUIET_TAIL      = 200;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic        ok;
        logic [62:0] cid;
        logic [63:0] upper;
        logic [63:0] lower;
    } identity_t;

    typedef struct packed {
        logic [47:0] mac;
        identity_t   ident;
    } pending_t;

    typedef struct packed {
        logic [47:0] mac;
        logic        typed;
        identity_t   want;
    } stim_row_t;

    localparam identity_t NO_IDENTITY = '0;
    localparam int DIRECTED_ROWS = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [mihd_pkg::MAC_W-1:0] mac_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        address_ok;
    logic [mihd_pkg::CLIENT_ID_W-1:0] client_id;
    logic [mihd_pkg::HASH_W-1:0]      uuid_upper;
    logic [mihd_pkg::HASH_W-1:0]      uuid_lower;

    logic [63:0] cid_seed;
    logic [63:0] uuid_a_seed;
    logic [63:0] uuid_b_seed;

    pending_t    identities_due[$];
    bit          sender_idle = 1'b0;
    bit          sink_idle = 1'b0;
    int          sink_hold = 0;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          derived_count = 0;
    int          rejected_count = 0;

    stim_row_t   directed_rows [DIRECTED_ROWS] = '{
        '{48'h000000000000, 1'b1, NO_IDENTITY},
        '{48'hFFFFFFFFFFFF, 1'b1, NO_IDENTITY},
        '{48'h010000000000, 1'b1, NO_IDENTITY},
        '{48'h01FFFFFFFFFF, 1'b1, NO_IDENTITY},
        '{48'hFF0000000000, 1'b1, NO_IDENTITY},
        '{48'hFFFFFFFFFFFE, 1'b1, NO_IDENTITY},
        '{48'h555555555555, 1'b1, NO_IDENTITY},
        '{48'h000000000001, 1'b0, NO_IDENTITY},
        '{48'hFEFFFFFFFFFF, 1'b0, NO_IDENTITY},
        '{48'hFCFFFFFFFFFF, 1'b0, NO_IDENTITY},
        '{48'h020000000000, 1'b0, NO_IDENTITY},
        '{48'h800000000000, 1'b0, NO_IDENTITY},
        '{48'h000000000080, 1'b0, NO_IDENTITY},
        '{48'h0000000000FF, 1'b0, NO_IDENTITY},
        '{48'h00FF00FF00FF, 1'b0, NO_IDENTITY},
        '{48'hAAAAAAAAAAAA, 1'b0, NO_IDENTITY},
        '{48'h001122334455, 1'b0, NO_IDENTITY},
        '{48'hFEDCBA987654, 1'b0, NO_IDENTITY},
        '{48'h3C0000000000, 1'b0, NO_IDENTITY},
        '{48'h00000000FF00, 1'b0, NO_IDENTITY}
    };

    mac_identity_hash_derivation uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mac_address (mac_address),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .address_ok  (address_ok),
        .client_id   (client_id),
        .uuid_upper  (uuid_upper),
        .uuid_lower  (uuid_lower)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [191:0] s,
                                             input int n);
        logic [63:0] acc;
        int          i;
        acc = h;
        for (i = 0; i < n; i++)
        begin
            acc = (acc ^ {56'd0, s[8*(n-1-i) +: 8]}) * FNV_PRIME_64;
        end
        return acc;
    endfunction

    function automatic logic [63:0] byte_reverse(input logic [63:0] v);
        logic [63:0] r;
        int          k;
        for (k = 0; k < 8; k++)
        begin
            r[63-8*k -: 8] = v[8*k +: 8];
        end
        return r;
    endfunction

    function automatic identity_t derive_identity(input logic [47:0] mac);
        identity_t   r;
        logic [63:0] h_cid;
        logic [63:0] up;
        logic [63:0] lo;
        r = NO_IDENTITY;
        if (mac[40] || mac == 48'h0 || mac == 48'hFFFFFFFFFFFF)
        begin
            return r;
        end
        h_cid = fnv_fold(cid_seed, {144'd0, mac}, MAC_LEN);
        up = byte_reverse(fnv_fold(uuid_a_seed, {144'd0, mac}, MAC_LEN));
        lo = byte_reverse(fnv_fold(uuid_b_seed, {144'd0, mac}, MAC_LEN));
        up[15:8] = {4'h5, up[11:8]};
        lo[63:56] = {2'b10, lo[61:56]};
        r.ok = 1'b1;
        r.cid = (h_cid[62:0] == 63'd0) ? 63'd1 : h_cid[62:0];
        r.upper = up;
        r.lower = lo;
        return r;
    endfunction

    function automatic logic [47:0] random_mac();
        logic [63:0] r;
        logic [47:0] m;
        int          sel;
        r = {$urandom, $urandom};
        m = r[47:0];
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            m[40] = 1'b0;
            if (m == 48'h0)
            begin
                m = 48'h1;
            end
        end
        else if (sel < 85)
        begin
            m[40] = 1'b1;
        end
        else if (sel < 90)
        begin
            m = 48'h1 << $urandom_range(0, 47);
        end
        else if (sel < 93)
        begin
            m = 48'h0;
        end
        else if (sel < 96)
        begin
            m = 48'hFFFFFFFFFFFF;
        end
        else
        begin
            m = ~(48'h1 << $urandom_range(0, 47));
        end
        return m;
    endfunction

    task automatic send_mac(input logic [47:0] mac, input identity_t ident);
        pending_t p;
        int       gap;
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        p.mac = mac;
        p.ident = ident;
        identities_due.push_back(p);
        in_valid = 1'b1;
        mac_address = mac;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic check_beat();
        pending_t  p;
        identity_t got;
        got = '{address_ok, client_id, uuid_upper, uuid_lower};
        if (identities_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("unexpected beat: ok %0b cid %h upper %h lower %h",
                         address_ok, client_id, uuid_upper, uuid_lower);
            end
        end
        else
        begin
            p = identities_due.pop_front();
            if (p.ident.ok)
            begin
                derived_count++;
            end
            else
            begin
                rejected_count++;
            end
            if (got.ok !== p.ident.ok || got.cid !== p.ident.cid ||
                got.upper !== p.ident.upper || got.lower !== p.ident.lower)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("mismatch mac %h: ok exp %0b got %0b, cid exp %h got %h",
                             p.mac, p.ident.ok, got.ok, p.ident.cid, got.cid);
                    $display("    upper exp %h got %h, lower exp %h got %h",
                             p.ident.upper, got.upper, p.ident.lower, got.lower);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_ready = 1'b0;
            sink_hold--;
        end
        else if (sink_idle && $urandom_range(0, 4) == 0)
        begin
            out_ready = 1'b0;
            sink_hold = $urandom_range(1, 9) - 1;
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL mac_identity_hash_derivation");
            $finish;
        end
        else if (rst_n && out_valid && out_ready)
        begin
            check_beat();
        end
    end

    initial
    begin
        int i;
        logic [47:0] m;
        cid_seed = fnv_fold(FNV_OFFSET_64, CLIENT_TAG_STR, CLIENT_TAG_LEN);
        uuid_a_seed = fnv_fold(FNV_OFFSET_64, UUID_A_DOMAIN, UUID_DOMAIN_LEN);
        uuid_b_seed = fnv_fold(FNV_OFFSET_64, UUID_B_DOMAIN, UUID_DOMAIN_LEN);
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        sender_idle = 1'b1;
        sink_idle = 1'b1;
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].typed)
            begin
                send_mac(directed_rows[i].mac, directed_rows[i].want);
            end
            else
            begin
                send_mac(directed_rows[i].mac, derive_identity(directed_rows[i].mac));
            end
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                sender_idle = 1'b0;
                sink_idle = 1'b0;
            end
            else if (i % 100 == 0)
            begin
                sender_idle = $urandom_range(0, 1);
                sink_idle = $urandom_range(0, 1);
            end
            m = random_mac();
            send_mac(m, derive_identity(m));
        end
        in_valid = 1'b0;

        while (identities_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);

        $display("Checked %0d derived identities and %0d rejected addresses in %0d cycles.",
                 derived_count, rejected_count, cycle_count);
        if (fail_count == 0)
        begin
            $display("PASS mac_identity_hash_derivation");
        end
        else
        begin
            $display("%0d beats failed.", fail_count);
            $display("FAIL mac_identity_hash_derivation");
        end
        $finish;
    end

endmodule
